// ----- rtl/task_lease_table_top_macros.svh -----
// Assertion helpers used by tlt_ctrl.
`ifndef TASK_LEASE_TABLE_TOP_MACROS_SVH
`define TASK_LEASE_TABLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define TLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TLT_ASSERT(lbl, prop, msg)
`define TLT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- rtl/tlt_pkg.sv -----
package tlt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam logic [31:0] LEASE_RESET = 32'd45000;
  localparam logic [2:0]  LEASE_ADDR  = 3'd0;

  localparam logic [2:0] REQ_SUBMIT  = 3'd0;
  localparam logic [2:0] REQ_CLAIM   = 3'd1;
  localparam logic [2:0] REQ_PUBLISH = 3'd2;
  localparam logic [2:0] REQ_CANCEL  = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;
  localparam logic [2:0] REQ_READ    = 3'd5;

  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_LEASED    = 3'd1;
  localparam logic [2:0] ST_SUCCEEDED = 3'd2;
  localparam logic [2:0] ST_FAILED    = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;

  localparam logic [1:0] RS_SUCCEEDED = 2'd0;
  localparam logic [1:0] RS_CANCELLED = 2'd1;

  localparam logic [3:0] OC_DONE        = 4'd0;
  localparam logic [3:0] OC_UPDATED     = 4'd1;
  localparam logic [3:0] OC_RENEWED     = 4'd2;
  localparam logic [3:0] OC_LEASED      = 4'd3;
  localparam logic [3:0] OC_PUBLISHED   = 4'd4;
  localparam logic [3:0] OC_CANCELLED   = 4'd5;
  localparam logic [3:0] OC_EMPTY       = 4'd6;
  localparam logic [3:0] OC_MISSING     = 4'd7;
  localparam logic [3:0] OC_TERMINAL    = 4'd8;
  localparam logic [3:0] OC_STALE       = 4'd9;
  localparam logic [3:0] OC_UNCLAIMABLE = 4'd10;

  localparam int unsigned NUM_CNT = 7;
  localparam logic [2:0] CNT_SUBMITTED = 3'd0;
  localparam logic [2:0] CNT_CLAIMED   = 3'd1;
  localparam logic [2:0] CNT_RENEWED   = 3'd2;
  localparam logic [2:0] CNT_RECLAIMED = 3'd3;
  localparam logic [2:0] CNT_PUBLISHED = 3'd4;
  localparam logic [2:0] CNT_STALE     = 3'd5;
  localparam logic [2:0] CNT_CANCELLED = 3'd6;

  typedef struct packed {
    logic [31:0] task_id;
    logic [2:0]  status;
    logic [15:0] owner;
    logic [31:0] expiry;
  } entry_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- rtl/tlt_ram.sv -----
module tlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/tlt_cfg.sv -----
module tlt_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] lease_duration
);

  import tlt_pkg::*;

  logic [31:0] lease_r;
  logic        wr_hit;

  assign wr_hit = psel && penable && pwrite && (paddr == LEASE_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lease_r <= LEASE_RESET;
    end else if (wr_hit) begin
      lease_r <= pwdata;
    end
  end

  assign prdata         = (paddr == LEASE_ADDR) ? lease_r : 32'd0;
  assign pready         = 1'b1;
  assign lease_duration = lease_r;

endmodule

// ----- rtl/tlt_ctrl.sv -----
module tlt_ctrl #(
  parameter int unsigned Depth = tlt_pkg::TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_req_type,
  input  logic [31:0]              in_task_id,
  input  logic [15:0]              in_node_id,
  input  logic [1:0]               in_result_status,
  input  logic [2:0]               in_counter_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_accepted,
  output logic [3:0]               out_outcome,
  output logic [2:0]               out_entry_state,
  output logic [15:0]              out_lease_owner,
  output logic [31:0]              out_counter_value,
  input  logic [31:0]              lease_duration,
  output logic                     rd_en,
  output logic [$clog2(Depth)-1:0] rd_addr,
  input  tlt_pkg::entry_t          rd_data,
  output logic                     wr_en,
  output logic [$clog2(Depth)-1:0] wr_addr,
  output tlt_pkg::entry_t          wr_data
);

  import tlt_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_ACT, S_FIN} state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  req_r, req_nxt;
  logic [31:0] id_r, id_nxt;
  logic [15:0] node_r, node_nxt;
  logic [1:0]  rstat_r, rstat_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] cnt_r [NUM_CNT];
  logic [31:0] cnt_nxt [NUM_CNT];
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic        pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic        reclaim_en_r, reclaim_en_nxt;
  logic        found_r, found_nxt;
  logic [AW-1:0] hit_r, hit_nxt;
  entry_t      hit_e_r, hit_e_nxt;
  logic        res_acc_r, res_acc_nxt;
  logic [3:0]  res_outc_r, res_outc_nxt;
  logic [2:0]  res_est_r, res_est_nxt;
  logic [15:0] res_own_r, res_own_nxt;
  logic [31:0] res_cval_r, res_cval_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_acc_r, out_acc_nxt;
  logic [3:0]  out_outc_r, out_outc_nxt;
  logic [2:0]  out_est_r, out_est_nxt;
  logic [15:0] out_own_r, out_own_nxt;
  logic [31:0] out_cval_r, out_cval_nxt;

  entry_t e_post, act_e;
  logic   rcl;
  logic   act_wr;
  logic [AW-1:0] act_addr;
  logic [31:0] new_expiry;

  assign new_expiry = sat_add32(now_r, lease_duration);

  // expired lease seen on the read data during a claim or publish sweep goes back to the queue
  always_comb begin
    rcl    = pend_r && reclaim_en_r && (rd_data.status == ST_LEASED) &&
             (rd_data.expiry <= now_r);
    e_post = rd_data;
    if (rcl) begin
      e_post.status = ST_QUEUED;
      e_post.owner  = 16'd0;
      e_post.expiry = 32'd0;
    end
  end

  assign rd_en   = (state_r == S_SWEEP) && (rd_cnt_r < fill_r);
  assign rd_addr = rd_cnt_r[AW-1:0];
  assign wr_en   = (state_r == S_ACT) ? act_wr : ((state_r == S_SWEEP) && rcl);
  assign wr_addr = (state_r == S_ACT) ? act_addr : pend_addr_r;
  assign wr_data = (state_r == S_ACT) ? act_e : e_post;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    id_nxt         = id_r;
    node_nxt       = node_r;
    rstat_nxt      = rstat_r;
    fill_nxt       = fill_r;
    ptr_nxt        = ptr_r;
    now_nxt        = now_r;
    cnt_nxt        = cnt_r;
    rd_cnt_nxt     = rd_cnt_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = rd_cnt_r[AW-1:0];
    reclaim_en_nxt = reclaim_en_r;
    found_nxt      = found_r;
    hit_nxt        = hit_r;
    hit_e_nxt      = hit_e_r;
    res_acc_nxt    = res_acc_r;
    res_outc_nxt   = res_outc_r;
    res_est_nxt    = res_est_r;
    res_own_nxt    = res_own_r;
    res_cval_nxt   = res_cval_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_acc_nxt    = out_acc_r;
    out_outc_nxt   = out_outc_r;
    out_est_nxt    = out_est_r;
    out_own_nxt    = out_own_r;
    out_cval_nxt   = out_cval_r;
    act_wr         = 1'b0;
    act_addr       = hit_r;
    act_e          = hit_e_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_req_type;
          id_nxt         = in_task_id;
          node_nxt       = in_node_id;
          rstat_nxt      = in_result_status;
          res_acc_nxt    = 1'b0;
          res_outc_nxt   = OC_DONE;
          res_est_nxt    = ST_QUEUED;
          res_own_nxt    = 16'd0;
          res_cval_nxt   = 32'd0;
          rd_cnt_nxt     = '0;
          found_nxt      = 1'b0;
          reclaim_en_nxt = (in_req_type == REQ_CLAIM) || (in_req_type == REQ_PUBLISH);
          state_nxt      = S_FIN;
          if (in_req_type <= REQ_CANCEL && in_task_id == 32'd0) begin
            res_outc_nxt = OC_EMPTY;
          end else begin
            case (in_req_type)
              REQ_SUBMIT, REQ_CLAIM, REQ_PUBLISH, REQ_CANCEL: begin
                state_nxt = S_SWEEP;
              end
              REQ_TICK: begin
                now_nxt     = sat_add32(now_r, 32'd1);
                res_acc_nxt = 1'b1;
              end
              REQ_READ: begin
                if (in_counter_index < 3'(NUM_CNT)) begin
                  res_cval_nxt = cnt_r[in_counter_index];
                  res_acc_nxt  = 1'b1;
                end
              end
              default: begin
                res_acc_nxt = 1'b0;
              end
            endcase
          end
        end
      end

      S_SWEEP: begin
        if (rd_en) begin
          rd_cnt_nxt = rd_cnt_r + CW'(1);
        end
        pend_nxt = rd_en;
        if (pend_r && !found_r && rd_data.task_id == id_r) begin
          found_nxt = 1'b1;
          hit_nxt   = pend_addr_r;
          hit_e_nxt = e_post;
        end
        if (rcl) begin
          cnt_nxt[CNT_RECLAIMED] = sat_add32(cnt_r[CNT_RECLAIMED], 32'd1);
        end
        if (!rd_en && !pend_r) begin
          state_nxt = S_ACT;
        end
      end

      S_ACT: begin
        state_nxt = S_FIN;
        case (req_r)
          REQ_SUBMIT: begin
            res_acc_nxt = 1'b1;
            cnt_nxt[CNT_SUBMITTED] = sat_add32(cnt_r[CNT_SUBMITTED], 32'd1);
            act_wr = 1'b1;
            if (found_r) begin
              if (hit_e_r.status == ST_QUEUED) begin
                act_e.owner  = 16'd0;
                act_e.expiry = 32'd0;
              end
              res_outc_nxt = OC_UPDATED;
            end else begin
              act_addr      = ptr_r;
              act_e.task_id = id_r;
              act_e.status  = ST_QUEUED;
              act_e.owner   = 16'd0;
              act_e.expiry  = 32'd0;
              ptr_nxt = (ptr_r == AW'(Depth - 1)) ? '0 : ptr_r + AW'(1);
              if (fill_r != CW'(Depth)) begin
                fill_nxt = fill_r + CW'(1);
              end
              res_outc_nxt = OC_DONE;
            end
          end
          REQ_CLAIM: begin
            if (!found_r) begin
              res_outc_nxt = OC_MISSING;
            end else if (hit_e_r.status == ST_LEASED && node_r != 16'd0 &&
                         hit_e_r.owner == node_r) begin
              act_wr       = 1'b1;
              act_e.expiry = new_expiry;
              res_acc_nxt  = 1'b1;
              res_outc_nxt = OC_RENEWED;
              cnt_nxt[CNT_RENEWED] = sat_add32(cnt_r[CNT_RENEWED], 32'd1);
            end else if (hit_e_r.status != ST_QUEUED) begin
              res_outc_nxt = OC_UNCLAIMABLE;
            end else begin
              act_wr       = 1'b1;
              act_e.status = ST_LEASED;
              act_e.owner  = node_r;
              act_e.expiry = new_expiry;
              res_acc_nxt  = 1'b1;
              res_outc_nxt = OC_LEASED;
              cnt_nxt[CNT_CLAIMED] = sat_add32(cnt_r[CNT_CLAIMED], 32'd1);
            end
          end
          REQ_PUBLISH: begin
            if (!found_r) begin
              res_outc_nxt = OC_MISSING;
            end else if (hit_e_r.status >= ST_SUCCEEDED) begin
              res_outc_nxt = OC_TERMINAL;
            end else if (hit_e_r.status == ST_LEASED && hit_e_r.owner != 16'd0 &&
                         node_r != 16'd0 && hit_e_r.owner != node_r) begin
              res_outc_nxt = OC_STALE;
              cnt_nxt[CNT_STALE] = sat_add32(cnt_r[CNT_STALE], 32'd1);
            end else begin
              act_wr = 1'b1;
              if (rstat_r == RS_SUCCEEDED) begin
                act_e.status = ST_SUCCEEDED;
              end else if (rstat_r == RS_CANCELLED) begin
                act_e.status = ST_CANCELLED;
              end else begin
                act_e.status = ST_FAILED;
              end
              act_e.owner  = 16'd0;
              act_e.expiry = 32'd0;
              res_acc_nxt  = 1'b1;
              res_outc_nxt = OC_PUBLISHED;
              cnt_nxt[CNT_PUBLISHED] = sat_add32(cnt_r[CNT_PUBLISHED], 32'd1);
            end
          end
          default: begin
            if (!found_r) begin
              res_outc_nxt = OC_MISSING;
            end else begin
              if (hit_e_r.status != ST_CANCELLED) begin
                cnt_nxt[CNT_CANCELLED] = sat_add32(cnt_r[CNT_CANCELLED], 32'd1);
              end
              act_wr       = 1'b1;
              act_e.status = ST_CANCELLED;
              act_e.owner  = 16'd0;
              act_e.expiry = 32'd0;
              res_acc_nxt  = 1'b1;
              res_outc_nxt = OC_CANCELLED;
            end
          end
        endcase
        // a new submit is always a match afterwards; a miss elsewhere reports zeros
        if (found_r || req_r == REQ_SUBMIT) begin
          res_est_nxt = act_e.status;
          res_own_nxt = act_e.owner;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = res_acc_r;
          out_outc_nxt  = res_outc_r;
          out_est_nxt   = res_est_r;
          out_own_nxt   = res_own_r;
          out_cval_nxt  = res_cval_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      ptr_r       <= '0;
      now_r       <= 32'd0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_r[i] <= 32'd0;
      end
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      now_r       <= now_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    id_r         <= id_nxt;
    node_r       <= node_nxt;
    rstat_r      <= rstat_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    pend_addr_r  <= pend_addr_nxt;
    reclaim_en_r <= reclaim_en_nxt;
    found_r      <= found_nxt;
    hit_r        <= hit_nxt;
    hit_e_r      <= hit_e_nxt;
    res_acc_r    <= res_acc_nxt;
    res_outc_r   <= res_outc_nxt;
    res_est_r    <= res_est_nxt;
    res_own_r    <= res_own_nxt;
    res_cval_r   <= res_cval_nxt;
    out_acc_r    <= out_acc_nxt;
    out_outc_r   <= out_outc_nxt;
    out_est_r    <= out_est_nxt;
    out_own_r    <= out_own_nxt;
    out_cval_r   <= out_cval_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_acc_r;
  assign out_outcome       = out_outc_r;
  assign out_entry_state   = out_est_r;
  assign out_lease_owner   = out_own_r;
  assign out_counter_value = out_cval_r;

  `include "task_lease_table_top_macros.svh"

  `TLT_NEVER(a_fill_bound, fill_r > CW'(Depth), "fill count beyond table depth")
  `TLT_NEVER(a_sweep_rw_clash, wr_en && rd_en && (wr_addr == rd_addr), "read and write clash")
  `TLT_ASSERT(a_accept_busy, in_valid && in_ready |=> state_r != S_IDLE, "accept left idle")
  `TLT_ASSERT(a_out_from_fin, $rose(out_valid_r) |-> $past(state_r == S_FIN), "stray result")

endmodule

// ----- rtl/task_lease_table_top.sv -----
// Task lease table.
// Requests enter on in_valid/in_ready (submit, claim, publish, cancel, tick,
// counter read); each request gives exactly one result on out_valid/out_ready.
// The lease length is a register on the APB port at byte address 0.
// Entries live in one synchronous RAM. Submit, claim, publish and cancel
// sweep the filled part of the table, one entry per cycle, searching for the
// id; claim and publish also write back expired leases during the sweep.
// These requests pass through the sweep, action and finish states; the sweep
// covers fill entries (fill = entries in use, at most TableDepth) through the
// single RAM read port. Tick, counter read and empty-id requests go from idle
// straight to the finish state. One request is in flight at a time; a new
// one is taken in the cycle after the result has moved to the output register.
// A stalled receiver holds the result in the output register; the block then
// finishes the next request and waits until the output register frees up.
// Reset is synchronous: table emptied (fill count zero), time, counters and
// insert position cleared, lease length back to 45000. No clearing pass.
module task_lease_table_top #(
  parameter int unsigned TableDepth = tlt_pkg::TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_task_id,
  input  logic [15:0] in_node_id,
  input  logic [1:0]  in_result_status,
  input  logic [2:0]  in_counter_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [3:0]  out_outcome,
  output logic [2:0]  out_entry_state,
  output logic [15:0] out_lease_owner,
  output logic [31:0] out_counter_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import tlt_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);

  logic [31:0]   lease_duration;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;

  tlt_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .lease_duration (lease_duration)
  );

  tlt_ram #(
    .Width ($bits(entry_t)),
    .Depth (TableDepth)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tlt_ctrl #(
    .Depth (TableDepth)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_task_id        (in_task_id),
    .in_node_id        (in_node_id),
    .in_result_status  (in_result_status),
    .in_counter_index  (in_counter_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_outcome       (out_outcome),
    .out_entry_state   (out_entry_state),
    .out_lease_owner   (out_lease_owner),
    .out_counter_value (out_counter_value),
    .lease_duration    (lease_duration),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data)
  );

endmodule

// ----- bench/tb.sv -----
module tb;
  import tlt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned POOL_IDS    = 80;  // more ids than slots, so the ring wraps

  typedef struct packed {
    logic [2:0]  req;
    logic [31:0] id;
    logic [15:0] node;
    logic [1:0]  rstat;
    logic [2:0]  cidx;
  } lease_req_t;

  typedef struct packed {
    logic        acc;
    logic [3:0]  oc;
    logic [2:0]  st;
    logic [15:0] own;
    logic [31:0] cnt;
  } lease_resp_t;

  typedef struct packed {
    logic        typed;
    lease_req_t  rq;
    lease_resp_t rs;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_req_type = '0;
  logic [31:0] in_task_id = '0;
  logic [15:0] in_node_id = '0;
  logic [1:0]  in_result_status = '0;
  logic [2:0]  in_counter_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_accepted;
  logic [3:0]  out_outcome;
  logic [2:0]  out_entry_state;
  logic [15:0] out_lease_owner;
  logic [31:0] out_counter_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  task_lease_table_top dut (.*);

  always #5 clk = ~clk;

  // shadow copy of the table
  logic        tbl_used   [TABLE_DEPTH];
  logic [31:0] tbl_task   [TABLE_DEPTH];
  logic [2:0]  tbl_state  [TABLE_DEPTH];
  logic [15:0] tbl_owner  [TABLE_DEPTH];
  logic [31:0] tbl_expiry [TABLE_DEPTH];
  logic [5:0]  next_slot;
  logic [31:0] clock_ticks;
  logic [31:0] evt_count [NUM_CNT];
  logic [31:0] lease_len;

  lease_resp_t pending_resps[$];
  int unsigned errors, sent, checked, cycles;
  int unsigned stall_left;
  int unsigned rx_mode;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_used[i] = 1'b0; tbl_task[i] = '0; tbl_state[i] = ST_QUEUED;
      tbl_owner[i] = '0; tbl_expiry[i] = '0;
    end
    for (int i = 0; i < NUM_CNT; i++) evt_count[i] = '0;
    next_slot = '0;
    clock_ticks = '0;
    lease_len = LEASE_RESET;
  endfunction

  function automatic void return_expired();
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (tbl_used[i] && tbl_state[i] == ST_LEASED && tbl_expiry[i] <= clock_ticks) begin
        tbl_state[i] = ST_QUEUED; tbl_owner[i] = '0; tbl_expiry[i] = '0;
        evt_count[CNT_RECLAIMED] = add_sat(evt_count[CNT_RECLAIMED], 1);
      end
  endfunction

  function automatic int find_task(logic [31:0] id);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (tbl_used[i] && tbl_task[i] == id) return i;
    return -1;
  endfunction

  function automatic void count_event(logic [2:0] which);
    evt_count[which] = add_sat(evt_count[which], 1);
  endfunction

  function automatic lease_resp_t apply_lease_request(lease_req_t r);
    lease_resp_t o;
    int s;
    o = '0;
    s = -1;
    if (r.req <= REQ_CANCEL && r.id == 0) begin
      o.oc = OC_EMPTY;
    end else begin
      case (r.req)
        REQ_SUBMIT: begin
          s = find_task(r.id);
          if (s >= 0) begin
            if (tbl_state[s] == ST_QUEUED) begin
              tbl_owner[s] = '0; tbl_expiry[s] = '0;
            end
            o.oc = OC_UPDATED;
          end else begin
            s = next_slot;
            tbl_used[s] = 1'b1; tbl_task[s] = r.id; tbl_state[s] = ST_QUEUED;
            tbl_owner[s] = '0; tbl_expiry[s] = '0;
            next_slot = next_slot + 1;
            o.oc = OC_DONE;
          end
          count_event(CNT_SUBMITTED);
          o.acc = 1'b1;
        end
        REQ_CLAIM: begin
          return_expired();
          s = find_task(r.id);
          if (s < 0) o.oc = OC_MISSING;
          else if (tbl_state[s] == ST_LEASED && r.node != 0 && tbl_owner[s] == r.node) begin
            tbl_expiry[s] = add_sat(clock_ticks, lease_len);
            count_event(CNT_RENEWED);
            o.acc = 1'b1; o.oc = OC_RENEWED;
          end else if (tbl_state[s] != ST_QUEUED) o.oc = OC_UNCLAIMABLE;
          else begin
            tbl_state[s] = ST_LEASED; tbl_owner[s] = r.node;
            tbl_expiry[s] = add_sat(clock_ticks, lease_len);
            count_event(CNT_CLAIMED);
            o.acc = 1'b1; o.oc = OC_LEASED;
          end
        end
        REQ_PUBLISH: begin
          return_expired();
          s = find_task(r.id);
          if (s < 0) o.oc = OC_MISSING;
          else if (tbl_state[s] >= ST_SUCCEEDED) o.oc = OC_TERMINAL;
          else if (tbl_state[s] == ST_LEASED && tbl_owner[s] != 0 && r.node != 0 &&
                   tbl_owner[s] != r.node) begin
            count_event(CNT_STALE);
            o.oc = OC_STALE;
          end else begin
            tbl_state[s] = (r.rstat == RS_SUCCEEDED) ? ST_SUCCEEDED :
                           (r.rstat == RS_CANCELLED) ? ST_CANCELLED : ST_FAILED;
            tbl_owner[s] = '0; tbl_expiry[s] = '0;
            count_event(CNT_PUBLISHED);
            o.acc = 1'b1; o.oc = OC_PUBLISHED;
          end
        end
        REQ_CANCEL: begin
          s = find_task(r.id);
          if (s < 0) o.oc = OC_MISSING;
          else begin
            if (tbl_state[s] != ST_CANCELLED) count_event(CNT_CANCELLED);
            tbl_state[s] = ST_CANCELLED; tbl_owner[s] = '0; tbl_expiry[s] = '0;
            o.acc = 1'b1; o.oc = OC_CANCELLED;
          end
        end
        REQ_TICK: begin
          clock_ticks = add_sat(clock_ticks, 1);
          o.acc = 1'b1;
        end
        REQ_READ: begin
          if (r.cidx < NUM_CNT) begin
            o.cnt = evt_count[r.cidx];
            o.acc = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (s >= 0) begin
      o.st = tbl_state[s];
      o.own = tbl_owner[s];
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got %0h expected %0h", checked, field, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    lease_resp_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_resps.size() == 0) begin
        $display("MISMATCH unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        w = pending_resps.pop_front();
        if (out_accepted !== w.acc) report_mismatch("accepted", out_accepted, w.acc);
        if (out_outcome !== w.oc) report_mismatch("outcome", out_outcome, w.oc);
        if (out_entry_state !== w.st) report_mismatch("entry_state", out_entry_state, w.st);
        if (out_lease_owner !== w.own) report_mismatch("lease_owner", out_lease_owner, w.own);
        if (out_counter_value !== w.cnt)
          report_mismatch("counter_value", out_counter_value, w.cnt);
      end
      checked++;
    end
  end

  // receiver back-pressure: mode 0 never stalls, 1 short stalls, 2 some long ones
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_mode != 0 && $urandom_range(0, 3) == 0) begin
      stall_left <= (rx_mode == 2 && $urandom_range(0, 9) == 0) ?
                    $urandom_range(20, 60) : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(lease_req_t r, logic typed, lease_resp_t want, bit gaps);
    int unsigned gap;
    lease_resp_t predicted;
    in_valid <= 1'b1;
    in_req_type <= r.req;
    in_task_id <= r.id;
    in_node_id <= r.node;
    in_result_status <= r.rstat;
    in_counter_index <= r.cidx;
    do @(posedge clk); while (!in_ready);
    predicted = apply_lease_request(r);
    pending_resps.push_back(typed ? want : predicted);
    sent++;
    gap = 0;
    if (gaps && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every outstanding request has its result
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_resps.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_lease(logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= LEASE_ADDR; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v) report_mismatch("lease_duration readback", prdata, v);
    psel <= 1'b0; penable <= 1'b0;
    lease_len = v;
    @(posedge clk);
  endtask

  function automatic lease_req_t random_request();
    lease_req_t r;
    int unsigned p;
    p = $urandom_range(0, 99);
    r.req = (p < 25) ? REQ_SUBMIT : (p < 50) ? REQ_CLAIM : (p < 70) ? REQ_PUBLISH :
            (p < 78) ? REQ_CANCEL : (p < 93) ? REQ_TICK : (p < 98) ? REQ_READ :
            3'($urandom_range(6, 7));
    p = $urandom_range(0, 99);
    r.id = (p < 4) ? 32'd0 : (p < 10) ? 32'($urandom) : 32'($urandom_range(1, POOL_IDS));
    r.node = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    r.rstat = 2'($urandom_range(0, 3));
    r.cidx = 3'($urandom_range(0, 7));
    return r;
  endfunction

  function automatic directed_row_t row(logic typed, logic [2:0] rq, logic [31:0] id,
                                        logic [15:0] nd, logic [1:0] rst, logic [2:0] ci,
                                        logic acc, logic [3:0] oc, logic [2:0] st,
                                        logic [15:0] own, logic [31:0] cnt);
    directed_row_t d;
    d.typed = typed;
    d.rq = '{rq, id, nd, rst, ci};
    d.rs = '{acc, oc, st, own, cnt};
    return d;
  endfunction

  directed_row_t directed[$];
  logic [31:0] lease_settings[5] = '{32'd1, 32'd3, 32'hFFFF_FFFF, 32'd20, LEASE_RESET};

  initial begin
    clear_table();
    rx_mode = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(row(1, REQ_READ, 0, 0, 0, CNT_SUBMITTED, 1, OC_DONE, 0, 0, 0));
    directed.push_back(row(1, REQ_SUBMIT, 0, 0, 0, 0, 0, OC_EMPTY, 0, 0, 0));
    directed.push_back(row(1, REQ_SUBMIT, 32'hFFFF_FFFF, 16'hFFFF, 3, 7,
                           1, OC_DONE, ST_QUEUED, 0, 0));
    directed.push_back(row(1, REQ_SUBMIT, 32'hFFFF_FFFF, 0, 0, 0, 1, OC_UPDATED, ST_QUEUED, 0, 0));
    directed.push_back(row(1, REQ_CLAIM, 32'hFFFF_FFFF, 16'hFFFF, 0, 0,
                           1, OC_LEASED, ST_LEASED, 16'hFFFF, 0));
    directed.push_back(row(1, REQ_CLAIM, 32'hFFFF_FFFF, 16'hFFFF, 0, 0,
                           1, OC_RENEWED, ST_LEASED, 16'hFFFF, 0));
    directed.push_back(row(1, REQ_CLAIM, 32'hFFFF_FFFF, 16'd5, 0, 0,
                           0, OC_UNCLAIMABLE, ST_LEASED, 16'hFFFF, 0));
    directed.push_back(row(1, REQ_PUBLISH, 32'hFFFF_FFFF, 16'd7, 0, 0,
                           0, OC_STALE, ST_LEASED, 16'hFFFF, 0));
    directed.push_back(row(1, REQ_PUBLISH, 32'hFFFF_FFFF, 16'hFFFF, 3, 0,
                           1, OC_PUBLISHED, ST_FAILED, 0, 0));
    directed.push_back(row(1, REQ_PUBLISH, 32'hFFFF_FFFF, 16'hFFFF, 0, 0,
                           0, OC_TERMINAL, ST_FAILED, 0, 0));
    directed.push_back(row(1, REQ_CANCEL, 32'hFFFF_FFFF, 0, 0, 0,
                           1, OC_CANCELLED, ST_CANCELLED, 0, 0));
    directed.push_back(row(1, REQ_CANCEL, 32'hFFFF_FFFF, 0, 0, 0,
                           1, OC_CANCELLED, ST_CANCELLED, 0, 0));
    directed.push_back(row(1, REQ_CANCEL, 32'd1, 0, 0, 0, 0, OC_MISSING, 0, 0, 0));
    directed.push_back(row(1, REQ_CLAIM, 32'd1, 16'd1, 0, 0, 0, OC_MISSING, 0, 0, 0));
    directed.push_back(row(1, REQ_CLAIM, 0, 16'd1, 0, 0, 0, OC_EMPTY, 0, 0, 0));
    directed.push_back(row(1, REQ_PUBLISH, 0, 16'd1, 0, 0, 0, OC_EMPTY, 0, 0, 0));
    directed.push_back(row(1, REQ_CANCEL, 0, 0, 0, 0, 0, OC_EMPTY, 0, 0, 0));
    directed.push_back(row(1, REQ_TICK, 0, 0, 0, 0, 1, OC_DONE, 0, 0, 0));
    directed.push_back(row(1, REQ_READ, 0, 0, 0, 3'd7, 0, OC_DONE, 0, 0, 0));
    directed.push_back(row(1, 3'd6, 32'd9, 16'd9, 1, 1, 0, 0, 0, 0, 0));
    directed.push_back(row(1, 3'd7, 32'd9, 16'd9, 1, 1, 0, 0, 0, 0, 0));
    // lease to node zero, then anyone may publish
    directed.push_back(row(0, REQ_SUBMIT, 32'd2, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(0, REQ_CLAIM, 32'd2, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(0, REQ_PUBLISH, 32'd2, 16'd9, 1, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(1, REQ_READ, 0, 0, 0, CNT_CANCELLED, 1, OC_DONE, 0, 0, 32'd1));

    foreach (directed[i]) send_request(directed[i].rq, directed[i].typed, directed[i].rs, 1);
    wait_drained();

    foreach (lease_settings[ph]) begin
      write_lease(lease_settings[ph]);
      rx_mode = ph % 3;
      for (int n = 0; n < 350; n++) begin
        // a stretch with no sender gaps in the middle of each phase
        send_request(random_request(), 0, '0, !(n >= 100 && n < 160));
        if (n == 200) wait_drained();
      end
      wait_drained();
    end

    rx_mode = 1;
    repeat (20) @(posedge clk);
    $display("Sent %0d requests over %0d lease settings, checked %0d results, %0d mismatches",
             sent, 5, checked, errors);
    $display("Covered submit, claim, renew, expiry reclaim, publish, cancel, tick and reads");
    if (errors == 0 && pending_resps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
